// ===== rtl/cantp_pkg.sv =====
// ----------------------------------------------------------------------------
// cantp_pkg
// Shared types and constants of the CAN transport-layer message reassembler.
// ----------------------------------------------------------------------------
`default_nettype none

package cantp_pkg;

  // Default sizing of the block
  localparam int NUM_CHANNELS_DEF      = 8;
  localparam int MAX_MESSAGE_BYTES_DEF = 128;

  // Item opcodes
  localparam logic [1:0] OP_FRAME  = 2'd0;
  localparam logic [1:0] OP_CHECK  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Frame types (high nibble of the protocol control byte)
  localparam logic [3:0] FT_SINGLE = 4'd0;
  localparam logic [3:0] FT_FIRST  = 4'd1;
  localparam logic [3:0] FT_CONSEC = 4'd2;

  // Payload sizes and limits
  localparam logic [2:0]  FF_DATA_BYTES = 3'd4;
  localparam logic [2:0]  SF_MAX_BYTES  = 3'd7;
  localparam logic [2:0]  CF_MAX_BYTES  = 3'd7;
  localparam logic [11:0] COUNT_MAX     = 12'hFFF;

  // Per-channel bookkeeping, held in the channel table memory
  typedef struct packed {
    logic [11:0] declared_length;
    logic [11:0] received_count;
    logic [3:0]  last_sequence;
    logic [3:0]  stored_security;
    logic [7:0]  stored_sender;
    logic        assembling;
    logic        already_read;
  } chan_meta_t;

  // Result of one item, held until the output register is free
  typedef struct packed {
    logic        status;
    logic [11:0] msg_length;
    logic [3:0]  sec_lvl;
    logic [7:0]  sender_id;
    logic [7:0]  read_byte;
    logic        completed;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/cantp_in_if.sv =====
// ----------------------------------------------------------------------------
// cantp_in_if
// Item channel into the reassembler: valid/ready handshake and item fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface cantp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [2:0] channel;
  logic [3:0] frame_len;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic [7:0] byte4;
  logic [7:0] byte5;
  logic [7:0] byte6;
  logic [7:0] byte7;
  logic [6:0] read_index;

  modport source (
    output valid, opcode, channel, frame_len,
    output byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7, read_index,
    input  ready
  );

  modport sink (
    input  valid, opcode, channel, frame_len,
    input  byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7, read_index,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/cantp_out_if.sv =====
// ----------------------------------------------------------------------------
// cantp_out_if
// Result channel out of the reassembler: valid/ready handshake and fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface cantp_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [11:0] msg_length;
  logic [3:0]  sec_lvl;
  logic [7:0]  sender_id;
  logic [7:0]  read_byte;
  logic        completed;

  modport source (
    output valid, status, msg_length, sec_lvl, sender_id,
    output read_byte, completed,
    input  ready
  );

  modport sink (
    input  valid, status, msg_length, sec_lvl, sender_id,
    input  read_byte, completed,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/cantp_ram.sv =====
// ----------------------------------------------------------------------------
// cantp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cantp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/can_tp_message_reassembler.sv =====
// ----------------------------------------------------------------------------
// can_tp_message_reassembler
// Per-channel CAN transport-layer receive reassembly with inbox check/read.
// ----------------------------------------------------------------------------
// The block handles one item at a time. Every item first reads its channel's
// bookkeeping from the channel table through its registered read port, then,
// where it changes, updates it in a single write. Frame payload bytes go into
// a byte-wide message store one byte per cycle: 4 bytes for a first frame, up
// to 7 for single and consecutive frames. A read item that returns a stored
// byte also reads it from the store before it responds. A stalled result
// holds the block in its response state until the transfer completes. Channel
// bookkeeping resets to zero through per-channel valid flags; the message
// store needs no clearing, since only bytes written by the current message
// are ever read back.
// ----------------------------------------------------------------------------
`default_nettype none

module can_tp_message_reassembler #(
  parameter int NUM_CHANNELS      = cantp_pkg::NUM_CHANNELS_DEF,
  parameter int MAX_MESSAGE_BYTES = cantp_pkg::MAX_MESSAGE_BYTES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cantp_in_if.sink    in_chan,
  cantp_out_if.source out_chan
);

  // Widths derived from the sizing parameters
  localparam int CIW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SDEPTH = NUM_CHANNELS * MAX_MESSAGE_BYTES;
  localparam int SAW = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int MW = $bits(cantp_pkg::chan_meta_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_META,
    S_WRITE,
    S_RDATA,
    S_RESP
  } state_t;

  state_t state_r;

  // Captured item
  logic [1:0]     op_r;
  logic [CIW-1:0] ch_idx_r;
  logic           item_ok_r;
  logic [3:0]     flen_r;
  logic [7:0]     bytes_r [8];
  logic [6:0]     ridx_r;

  // Byte write loop
  logic [12:0] wr_pos_r;
  logic [2:0]  wr_src_r;
  logic [2:0]  wr_left_r;

  // Channel table valid flags (cleared by reset)
  logic [NUM_CHANNELS-1:0] meta_vld_r;

  // Pending result and output register
  cantp_pkg::result_t pend_r;
  cantp_pkg::result_t out_r;
  logic               out_valid_r;

  // Channel table and message store ports
  logic [MW-1:0]        meta_rdata;
  cantp_pkg::chan_meta_t meta_cur;
  cantp_pkg::chan_meta_t meta_new;
  logic                 meta_we;
  logic                 in_xfer;
  logic [CIW-1:0]       in_ch_idx;
  logic                 store_we;
  logic                 store_re;
  logic [SAW-1:0]       ch_base;
  logic [SAW-1:0]       store_waddr;
  logic [SAW-1:0]       store_raddr;
  logic [7:0]           store_rdata;

  // Item decode
  logic [3:0]  ftype;
  logic [3:0]  nib;
  logic [3:0]  seq_next;
  logic [2:0]  n_sf;
  logic [2:0]  n_cf;
  logic [12:0] total_wide;
  logic [11:0] total_sat;
  logic        accepted;
  logic        done;
  logic        rd_hit;
  logic [2:0]  n_bytes;
  logic [2:0]  src_start;
  logic [12:0] pos_start;
  cantp_pkg::result_t res;

  assign in_xfer   = in_chan.valid && in_chan.ready;
  assign in_ch_idx = CIW'(in_chan.channel);

  // Handshake: take a new item only when idle
  assign in_chan.ready = (state_r == S_IDLE);

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_r.status;
  assign out_chan.msg_length = out_r.msg_length;
  assign out_chan.sec_lvl    = out_r.sec_lvl;
  assign out_chan.sender_id  = out_r.sender_id;
  assign out_chan.read_byte  = out_r.read_byte;
  assign out_chan.completed  = out_r.completed;

  // Store addressing: one region of MAX_MESSAGE_BYTES per channel
  assign ch_base     = SAW'(ch_idx_r) * SAW'(MAX_MESSAGE_BYTES);
  assign store_waddr = ch_base + SAW'(wr_pos_r);
  assign store_raddr = ch_base + SAW'(ridx_r);
  assign store_we    = (state_r == S_WRITE) && (32'(wr_pos_r) < MAX_MESSAGE_BYTES);

  cantp_ram #(
    .WIDTH (MW),
    .DEPTH (NUM_CHANNELS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (ch_idx_r),
    .wdata (meta_new),
    .re    (in_xfer),
    .raddr (in_ch_idx),
    .rdata (meta_rdata)
  );

  cantp_ram #(
    .WIDTH (8),
    .DEPTH (SDEPTH)
  ) u_store_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (bytes_r[wr_src_r]),
    .re    (store_re),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  // Decode the captured item against the channel's bookkeeping and work out
  // the updated entry, the bytes to write and the result.
  always_comb begin
    meta_cur   = meta_vld_r[ch_idx_r] ? cantp_pkg::chan_meta_t'(meta_rdata)
                                      : cantp_pkg::chan_meta_t'('0);
    meta_new   = meta_cur;
    meta_we    = 1'b0;
    accepted   = 1'b0;
    done       = 1'b0;
    rd_hit     = 1'b0;
    n_bytes    = 3'd0;
    src_start  = 3'd1;
    pos_start  = 13'd0;
    res        = '0;
    res.status = 1'b1;

    ftype    = bytes_r[0][7:4];
    nib      = bytes_r[0][3:0];
    seq_next = meta_cur.last_sequence + 4'd1;
    n_sf     = (nib > 4'(cantp_pkg::SF_MAX_BYTES)) ? cantp_pkg::SF_MAX_BYTES : nib[2:0];
    if (flen_r == 4'd0) begin
      n_cf = 3'd0;
    end else if (flen_r > 4'd8) begin
      n_cf = cantp_pkg::CF_MAX_BYTES;
    end else begin
      n_cf = 3'(flen_r - 4'd1);
    end
    total_wide = {1'b0, meta_cur.received_count} + {10'd0, n_cf};
    total_sat  = total_wide[12] ? cantp_pkg::COUNT_MAX : total_wide[11:0];

    if ((state_r == S_META) && item_ok_r) begin
      case (op_r)
        cantp_pkg::OP_FRAME: begin
          case (ftype)
            cantp_pkg::FT_SINGLE: begin
              meta_new.declared_length = {9'd0, n_sf};
              meta_new.received_count  = {9'd0, n_sf};
              meta_new.last_sequence   = 4'd0;
              meta_new.stored_security = 4'd0;
              meta_new.assembling      = 1'b0;
              meta_new.already_read    = 1'b0;
              n_bytes  = n_sf;
              accepted = 1'b1;
              done     = (n_sf != 3'd0);
            end
            cantp_pkg::FT_FIRST: begin
              meta_new.declared_length = {nib, bytes_r[1]};
              meta_new.last_sequence   = bytes_r[2][3:0];
              meta_new.stored_security = bytes_r[2][7:4];
              meta_new.stored_sender   = bytes_r[3];
              meta_new.received_count  = {9'd0, cantp_pkg::FF_DATA_BYTES};
              meta_new.assembling      = 1'b1;
              meta_new.already_read    = 1'b0;
              n_bytes   = cantp_pkg::FF_DATA_BYTES;
              src_start = 3'd4;
              accepted  = 1'b1;
            end
            cantp_pkg::FT_CONSEC: begin
              // Append only to a message in progress, and only in sequence
              if (meta_cur.assembling && (nib == seq_next)) begin
                meta_new.last_sequence  = nib;
                meta_new.received_count = total_sat;
                if (total_sat >= meta_cur.declared_length) begin
                  meta_new.assembling = 1'b0;
                  done                = 1'b1;
                end
                n_bytes   = n_cf;
                pos_start = {1'b0, meta_cur.received_count};
                accepted  = 1'b1;
              end
            end
            default: begin
            end
          endcase
          meta_we        = accepted;
          res.status     = !accepted;
          res.msg_length = meta_new.declared_length;
          res.sec_lvl    = meta_new.stored_security;
          res.sender_id  = meta_new.stored_sender;
          res.completed  = done;
        end
        cantp_pkg::OP_CHECK,
        cantp_pkg::OP_READ: begin
          // Ready: complete, non-empty, and for a check not yet read
          if (!meta_cur.assembling && (meta_cur.declared_length != 12'd0) &&
              !((op_r == cantp_pkg::OP_CHECK) && meta_cur.already_read)) begin
            res.status     = 1'b0;
            res.msg_length = meta_cur.declared_length;
            res.sec_lvl    = meta_cur.stored_security;
            res.sender_id  = meta_cur.stored_sender;
            if (op_r == cantp_pkg::OP_READ) begin
              meta_new.already_read = 1'b1;
              meta_we               = 1'b1;
              rd_hit = ({5'd0, ridx_r} < meta_cur.declared_length) &&
                       ({5'd0, ridx_r} < meta_cur.received_count) &&
                       (32'(ridx_r) < MAX_MESSAGE_BYTES);
            end
          end
        end
        default: begin
        end
      endcase
    end
    store_re = rd_hit;
  end

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      meta_vld_r  <= '0;
    end else begin
      // Drop the result once its transfer completes, unless a new one follows
      if (out_valid_r && out_chan.ready && (state_r != S_RESP)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            op_r       <= in_chan.opcode;
            ch_idx_r   <= in_ch_idx;
            item_ok_r  <= (32'(in_chan.channel) < NUM_CHANNELS) &&
                          (in_chan.opcode != cantp_pkg::OP_UNUSED);
            flen_r     <= in_chan.frame_len;
            bytes_r[0] <= in_chan.byte0;
            bytes_r[1] <= in_chan.byte1;
            bytes_r[2] <= in_chan.byte2;
            bytes_r[3] <= in_chan.byte3;
            bytes_r[4] <= in_chan.byte4;
            bytes_r[5] <= in_chan.byte5;
            bytes_r[6] <= in_chan.byte6;
            bytes_r[7] <= in_chan.byte7;
            ridx_r     <= in_chan.read_index;
            state_r    <= S_META;
          end
        end
        S_META: begin
          if (meta_we) begin
            meta_vld_r[ch_idx_r] <= 1'b1;
          end
          pend_r    <= res;
          wr_pos_r  <= pos_start;
          wr_src_r  <= src_start;
          wr_left_r <= n_bytes;
          if (n_bytes != 3'd0) begin
            state_r <= S_WRITE;
          end else if (rd_hit) begin
            state_r <= S_RDATA;
          end else begin
            state_r <= S_RESP;
          end
        end
        S_WRITE: begin
          // Advance one payload byte per cycle
          wr_pos_r  <= wr_pos_r + 13'd1;
          wr_src_r  <= wr_src_r + 3'd1;
          wr_left_r <= wr_left_r - 3'd1;
          if (wr_left_r == 3'd1) begin
            state_r <= S_RESP;
          end
        end
        S_RDATA: begin
          pend_r.read_byte <= store_rdata;
          state_r          <= S_RESP;
        end
        S_RESP: begin
          // Hold until the output register is free
          if (!out_valid_r || out_chan.ready) begin
            out_r       <= pend_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_chan.ready)
    else $error("item accepted while the previous one is still in progress");

  a_completed_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.completed) |-> !out_r.status)
    else $error("completed message reported with a failing status");

  a_store_read_followed: assert property (@(posedge clk) disable iff (!rst_n)
    store_re |=> (state_r == S_RDATA))
    else $error("store read issued without a read-data cycle after it");

  a_write_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
    store_we |-> ((wr_left_r != 3'd0) && !meta_we && !store_re))
    else $error("store write outside the byte loop");
`endif

endmodule

`default_nettype wire
